// File: src/rbnp_pkg.sv
// shared constants for the ray box nearest pick block
package rbnp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int T_BITS    = 32;
   localparam int DIST_BITS = 31;
   localparam int Q_BITS    = 31;
   localparam int ID_BITS   = 32;
   localparam int NUM_AXES  = 3;
   localparam int NUM_DIVS  = 6;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [DIST_BITS-1:0] T_SAT = {DIST_BITS{1'b1}};

   // register indexes of the configuration port
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIR_Z    = 3'd5;

endpackage

// File: src/rbnp_div.sv
// restoring divider, one quotient bit per step, saturating signed result
module rbnp_div #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [COORD_WIDTH:0]           num_mag,
   input  logic [COORD_WIDTH-1:0]         den_mag,
   input  logic                           neg,
   output logic signed [rbnp_pkg::T_BITS-1:0] t
);

   localparam int HI_BITS = COORD_WIDTH + 1 - (rbnp_pkg::Q_BITS - rbnp_pkg::FRAC_BITS);
   localparam int LO_NUM  = rbnp_pkg::Q_BITS - rbnp_pkg::FRAC_BITS;

   logic [COORD_WIDTH:0]            rem_ff, rem_in;
   logic [rbnp_pkg::Q_BITS-1:0]     low_ff, low_in;
   logic [rbnp_pkg::Q_BITS-1:0]     q_ff, q_in;
   logic                            ovf_ff, ovf_in;
   logic                            neg_ff, neg_in;
   logic [COORD_WIDTH:0]            num_hi;
   logic [COORD_WIDTH+1:0]          rem2;
   logic [COORD_WIDTH+1:0]          den2;
   logic [rbnp_pkg::DIST_BITS-1:0]  mag;

   assign num_hi = {{(COORD_WIDTH + 1 - HI_BITS){1'b0}}, num_mag[COORD_WIDTH:LO_NUM]};
   assign rem2   = {rem_ff, low_ff[rbnp_pkg::Q_BITS-1]};
   assign den2   = {2'b00, den_mag};

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      q_in   = q_ff;
      ovf_in = ovf_ff;
      neg_in = neg_ff;
      if (load) begin
         rem_in = num_hi;
         low_in = {num_mag[LO_NUM-1:0], {rbnp_pkg::FRAC_BITS{1'b0}}};
         q_in   = '0;
         ovf_in = (num_hi >= {1'b0, den_mag});
         neg_in = neg;
      end else if (step) begin
         low_in = {low_ff[rbnp_pkg::Q_BITS-2:0], 1'b0};
         if (rem2 >= den2) begin
            rem_in = (COORD_WIDTH+1)'(rem2 - den2);
            q_in   = {q_ff[rbnp_pkg::Q_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem2[COORD_WIDTH:0];
            q_in   = {q_ff[rbnp_pkg::Q_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   assign mag = ovf_ff ? rbnp_pkg::T_SAT : q_ff;
   assign t   = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: src/rbnp_front.sv
// front end: takes boxes, forms slab numerators, flags parallel misses, queues jobs
module rbnp_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_WIDTH-1:0] origin [rbnp_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] dir    [rbnp_pkg::NUM_AXES],
   input  logic                          push,
   output logic                          full,
   input  logic signed [COORD_WIDTH-1:0] box_min [rbnp_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] box_max [rbnp_pkg::NUM_AXES],
   input  logic [rbnp_pkg::ID_BITS-1:0]  box_id,
   input  logic                          last_candidate,
   output logic                          job_valid,
   input  logic                          job_pop,
   output logic [COORD_WIDTH:0]          job_num_mag [rbnp_pkg::NUM_DIVS],
   output logic                          job_num_neg [rbnp_pkg::NUM_DIVS],
   output logic [rbnp_pkg::NUM_AXES-1:0] job_par,
   output logic                          job_par_miss,
   output logic [rbnp_pkg::ID_BITS-1:0]  job_id,
   output logic                          job_last
);

   logic [COORD_WIDTH:0]          mag_ff  [2][rbnp_pkg::NUM_DIVS];
   logic                          neg_ff  [2][rbnp_pkg::NUM_DIVS];
   logic [rbnp_pkg::NUM_AXES-1:0] par_ff  [2];
   logic                          miss_ff [2];
   logic [rbnp_pkg::ID_BITS-1:0]  id_ff   [2];
   logic                          last_ff [2];
   logic                          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]                    count_ff;

   logic signed [COORD_WIDTH:0]   diff    [rbnp_pkg::NUM_DIVS];
   logic [COORD_WIDTH:0]          mag_in  [rbnp_pkg::NUM_DIVS];
   logic                          neg_in  [rbnp_pkg::NUM_DIVS];
   logic [rbnp_pkg::NUM_AXES-1:0] par_in;
   logic                          miss_in;
   logic                          do_push;

   always_comb begin
      miss_in = 1'b0;
      for (int a = 0; a < rbnp_pkg::NUM_AXES; a++) begin
         diff[2*a]   = $signed({box_min[a][COORD_WIDTH-1], box_min[a]})
                     - $signed({origin[a][COORD_WIDTH-1], origin[a]});
         diff[2*a+1] = $signed({box_max[a][COORD_WIDTH-1], box_max[a]})
                     - $signed({origin[a][COORD_WIDTH-1], origin[a]});
         par_in[a] = (dir[a] == '0);
         if (par_in[a] && ((origin[a] < box_min[a]) || (origin[a] > box_max[a])))
            miss_in = 1'b1;
      end
      for (int k = 0; k < rbnp_pkg::NUM_DIVS; k++) begin
         neg_in[k] = diff[k][COORD_WIDTH];
         mag_in[k] = neg_in[k] ? (COORD_WIDTH+1)'(-diff[k]) : $unsigned(diff[k]);
      end
   end

   assign full      = (count_ff == 2'd2);
   assign do_push   = push && !full;
   assign job_valid = (count_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mag_ff[wr_ptr_ff]  <= mag_in;
         neg_ff[wr_ptr_ff]  <= neg_in;
         par_ff[wr_ptr_ff]  <= par_in;
         miss_ff[wr_ptr_ff] <= miss_in;
         id_ff[wr_ptr_ff]   <= box_id;
         last_ff[wr_ptr_ff] <= last_candidate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push)
            wr_ptr_ff <= !wr_ptr_ff;
         if (job_pop && job_valid)
            rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(job_pop && job_valid);
      end
   end

   assign job_num_mag  = mag_ff[rd_ptr_ff];
   assign job_num_neg  = neg_ff[rd_ptr_ff];
   assign job_par      = par_ff[rd_ptr_ff];
   assign job_par_miss = miss_ff[rd_ptr_ff];
   assign job_id       = id_ff[rd_ptr_ff];
   assign job_last     = last_ff[rd_ptr_ff];

endmodule

// File: src/rbnp_back.sv
// back end: six slab dividers, slab merge, nearest hit tracking, result queue
module rbnp_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_WIDTH-1:0] dir [rbnp_pkg::NUM_AXES],
   input  logic                          job_valid,
   output logic                          job_pop,
   input  logic [COORD_WIDTH:0]          job_num_mag [rbnp_pkg::NUM_DIVS],
   input  logic                          job_num_neg [rbnp_pkg::NUM_DIVS],
   input  logic [rbnp_pkg::NUM_AXES-1:0] job_par,
   input  logic                          job_par_miss,
   input  logic [rbnp_pkg::ID_BITS-1:0]  job_id,
   input  logic                          job_last,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_found,
   output logic [rbnp_pkg::ID_BITS-1:0]  rsp_best_entity,
   output logic [rbnp_pkg::DIST_BITS-1:0] rsp_nearest_distance
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_MERGE} state_type;

   localparam logic [4:0] LAST_STEP = 5'(rbnp_pkg::Q_BITS - 1);

   state_type                     state_ff;
   logic [4:0]                    cnt_ff;
   logic [rbnp_pkg::NUM_AXES-1:0] par_ff;
   logic                          miss_ff;
   logic [rbnp_pkg::ID_BITS-1:0]  id_ff;
   logic                          last_ff;

   logic [rbnp_pkg::DIST_BITS-1:0] best_dist_ff;
   logic [rbnp_pkg::ID_BITS-1:0]   best_id_ff;
   logic                           any_hit_ff;

   logic                           r_found_ff [2];
   logic [rbnp_pkg::ID_BITS-1:0]   r_id_ff    [2];
   logic [rbnp_pkg::DIST_BITS-1:0] r_dist_ff  [2];
   logic                           r_wr_ff, r_rd_ff;
   logic [1:0]                     out_cnt_ff;

   logic                           div_load, div_step;
   logic signed [rbnp_pkg::T_BITS-1:0] t [rbnp_pkg::NUM_DIVS];
   logic [COORD_WIDTH-1:0]         den_mag [rbnp_pkg::NUM_AXES];

   logic signed [rbnp_pkg::T_BITS:0] tmin, tmax, t_lo, t_hi;
   logic                           hit, take;
   logic [rbnp_pkg::DIST_BITS-1:0] hit_dist;
   logic                           res_push, res_pop;
   logic [rbnp_pkg::DIST_BITS-1:0] new_dist;
   logic [rbnp_pkg::ID_BITS-1:0]   new_id;
   logic                           new_any;

   assign job_pop  = (state_ff == ST_IDLE) && job_valid && (out_cnt_ff != 2'd2);
   assign div_load = job_pop;
   assign div_step = (state_ff == ST_RUN);

   for (genvar a = 0; a < rbnp_pkg::NUM_AXES; a++) begin : g_axis
      assign den_mag[a] = dir[a][COORD_WIDTH-1] ? COORD_WIDTH'(-dir[a]) : dir[a];
      for (genvar s = 0; s < 2; s++) begin : g_side
         rbnp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
            .clock   (clock),
            .load    (div_load),
            .step    (div_step),
            .num_mag (job_num_mag[2*a+s]),
            .den_mag (den_mag[a]),
            .neg     (job_num_neg[2*a+s] ^ dir[a][COORD_WIDTH-1]),
            .t       (t[2*a+s])
         );
      end
   end

   // slab merge over the three axes
   always_comb begin
      tmin = {1'b1, {rbnp_pkg::T_BITS{1'b0}}};
      tmax = {1'b0, {rbnp_pkg::T_BITS{1'b1}}};
      for (int a = 0; a < rbnp_pkg::NUM_AXES; a++) begin
         if (t[2*a] > t[2*a+1]) begin
            t_lo = (rbnp_pkg::T_BITS+1)'(t[2*a+1]);
            t_hi = (rbnp_pkg::T_BITS+1)'(t[2*a]);
         end else begin
            t_lo = (rbnp_pkg::T_BITS+1)'(t[2*a]);
            t_hi = (rbnp_pkg::T_BITS+1)'(t[2*a+1]);
         end
         if (!par_ff[a]) begin
            if (t_lo > tmin) tmin = t_lo;
            if (t_hi < tmax) tmax = t_hi;
         end
      end
      hit      = !miss_ff && (tmin <= tmax) && !tmax[rbnp_pkg::T_BITS];
      hit_dist = tmin[rbnp_pkg::T_BITS] ? '0 : tmin[rbnp_pkg::DIST_BITS-1:0];
      take     = hit && (!any_hit_ff || (hit_dist < best_dist_ff));
      new_dist = take ? hit_dist : best_dist_ff;
      new_id   = take ? id_ff : best_id_ff;
      new_any  = take || any_hit_ff;
   end

   assign res_push = (state_ff == ST_MERGE) && last_ff;
   assign res_pop  = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         par_ff       <= '0;
         miss_ff      <= 1'b0;
         id_ff        <= '0;
         last_ff      <= 1'b0;
         best_dist_ff <= rbnp_pkg::T_SAT;
         best_id_ff   <= '0;
         any_hit_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (job_pop) begin
                  par_ff   <= job_par;
                  miss_ff  <= job_par_miss;
                  id_ff    <= job_id;
                  last_ff  <= job_last;
                  cnt_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == LAST_STEP)
                  state_ff <= ST_MERGE;
            end
            ST_MERGE: begin
               if (last_ff) begin
                  best_dist_ff <= rbnp_pkg::T_SAT;
                  best_id_ff   <= '0;
                  any_hit_ff   <= 1'b0;
               end else begin
                  best_dist_ff <= new_dist;
                  best_id_ff   <= new_id;
                  any_hit_ff   <= new_any;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         r_found_ff[r_wr_ff] <= new_any;
         r_id_ff[r_wr_ff]    <= new_any ? new_id : '0;
         r_dist_ff[r_wr_ff]  <= new_any ? new_dist : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_wr_ff    <= 1'b0;
         r_rd_ff    <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         if (res_push) r_wr_ff <= !r_wr_ff;
         if (res_pop)  r_rd_ff <= !r_rd_ff;
         out_cnt_ff <= out_cnt_ff + 2'(res_push) - 2'(res_pop);
      end
   end

   assign rsp_empty            = (out_cnt_ff == 2'd0);
   assign rsp_found            = r_found_ff[r_rd_ff];
   assign rsp_best_entity      = r_id_ff[r_rd_ff];
   assign rsp_nearest_distance = r_dist_ff[r_rd_ff];

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (out_cnt_ff != 2'd2 || res_pop))
      else $error("result pushed into a full queue");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == LAST_STEP) |=> (state_ff == ST_MERGE))
      else $error("divide run did not end in merge");

   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      !any_hit_ff |-> (best_id_ff == '0 && best_dist_ff == rbnp_pkg::T_SAT))
      else $error("best hit state not clear without a hit");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !any_hit_ff)
      else $error("query state kept after last candidate");

endmodule

// File: src/ray_box_nearest_pick.sv
// top level of the ray box nearest pick block
// Tests a ray, whose origin and direction sit in six configuration registers
// (signed Q16.16), against a stream of axis-aligned boxes with the slab method
// and reports the nearest hit of each query. A request carries one box, its
// entity id and a last flag; a request with the last flag set ends the query
// and produces one response (found, entity id, distance), after which the
// nearest hit state is cleared. Each box passes the back end as a load, then
// the six restoring slab dividers running side by side (one quotient bit each
// per cycle), then a merge, before the next box is taken. The front end
// forms the slab numerators in the cycle a request is taken and holds up to two
// waiting requests, and up to two responses wait in the response queue, so
// either side may stall for a while without holding up the other. Write the
// configuration registers only while no request is in flight.
module ray_box_nearest_pick #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [rbnp_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_wdata,
   // request queue side
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [COORD_WIDTH-1:0]         req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]         req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]         req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0]         req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]         req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]         req_box_max_z,
   input  logic [rbnp_pkg::ID_BITS-1:0]          req_entity_id,
   input  logic                                  req_last_candidate,
   // response queue side
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic                                  rsp_found,
   output logic [rbnp_pkg::ID_BITS-1:0]          rsp_best_entity,
   output logic [rbnp_pkg::DIST_BITS-1:0]        rsp_nearest_distance
);

   // ray registers
   logic signed [COORD_WIDTH-1:0] origin_ff [rbnp_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] dir_ff    [rbnp_pkg::NUM_AXES];

   logic signed [COORD_WIDTH-1:0] box_min [rbnp_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] box_max [rbnp_pkg::NUM_AXES];

   // job queue between front and back
   logic                          job_valid, job_pop;
   logic [COORD_WIDTH:0]          job_num_mag [rbnp_pkg::NUM_DIVS];
   logic                          job_num_neg [rbnp_pkg::NUM_DIVS];
   logic [rbnp_pkg::NUM_AXES-1:0] job_par;
   logic                          job_par_miss;
   logic [rbnp_pkg::ID_BITS-1:0]  job_id;
   logic                          job_last;

   // writes to indexes beyond the register list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= COORD_WIDTH'(32'd65536);
      end else if (csr_we) begin
         case (csr_index)
            rbnp_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
            rbnp_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            rbnp_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            rbnp_pkg::CSR_DIR_X:    dir_ff[0]    <= csr_wdata;
            rbnp_pkg::CSR_DIR_Y:    dir_ff[1]    <= csr_wdata;
            rbnp_pkg::CSR_DIR_Z:    dir_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign box_min[0] = req_box_min_x;
   assign box_min[1] = req_box_min_y;
   assign box_min[2] = req_box_min_z;
   assign box_max[0] = req_box_max_x;
   assign box_max[1] = req_box_max_y;
   assign box_max[2] = req_box_max_z;

   // front end: numerators and parallel slab check
   rbnp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .origin         (origin_ff),
      .dir            (dir_ff),
      .push           (req_push),
      .full           (req_full),
      .box_min        (box_min),
      .box_max        (box_max),
      .box_id         (req_entity_id),
      .last_candidate (req_last_candidate),
      .job_valid      (job_valid),
      .job_pop        (job_pop),
      .job_num_mag    (job_num_mag),
      .job_num_neg    (job_num_neg),
      .job_par        (job_par),
      .job_par_miss   (job_par_miss),
      .job_id         (job_id),
      .job_last       (job_last)
   );

   // back end: dividers, merge and nearest hit tracking
   rbnp_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock                (clock),
      .reset                (reset),
      .dir                  (dir_ff),
      .job_valid            (job_valid),
      .job_pop              (job_pop),
      .job_num_mag          (job_num_mag),
      .job_num_neg          (job_num_neg),
      .job_par              (job_par),
      .job_par_miss         (job_par_miss),
      .job_id               (job_id),
      .job_last             (job_last),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_found            (rsp_found),
      .rsp_best_entity      (rsp_best_entity),
      .rsp_nearest_distance (rsp_nearest_distance)
   );

endmodule

// File: verif/testbench.sv
// self-checking testbench for the ray box nearest pick block
`timescale 1ns / 1ps

module testbench;

   localparam int CW        = 32;
   localparam int MAX_CYC   = 2000000;
   localparam int DRAIN_CYC = 200;
   localparam logic signed [63:0] SLAB_MAX = 64'sd2147483647;

   // one box request as driven on the input queue
   typedef struct packed {
      logic signed [CW-1:0] min_x, min_y, min_z;
      logic signed [CW-1:0] max_x, max_y, max_z;
      logic [rbnp_pkg::ID_BITS-1:0] id;
      logic                 last;
   } box_req_type;

   // one pick answer as seen on the response queue
   typedef struct packed {
      logic                           found;
      logic [rbnp_pkg::ID_BITS-1:0]   entity;
      logic [rbnp_pkg::DIST_BITS-1:0] distance;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [rbnp_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CW-1:0] csr_wdata = '0;
   logic req_push = 1'b0;
   logic req_full;
   box_req_type req_box = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_found;
   logic [rbnp_pkg::ID_BITS-1:0] rsp_best_entity;
   logic [rbnp_pkg::DIST_BITS-1:0] rsp_nearest_distance;

   ray_box_nearest_pick #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_full(req_full),
      .req_box_min_x(req_box.min_x), .req_box_min_y(req_box.min_y),
      .req_box_min_z(req_box.min_z), .req_box_max_x(req_box.max_x),
      .req_box_max_y(req_box.max_y), .req_box_max_z(req_box.max_z),
      .req_entity_id(req_box.id), .req_last_candidate(req_box.last),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_found(rsp_found),
      .rsp_best_entity(rsp_best_entity), .rsp_nearest_distance(rsp_nearest_distance)
   );

   always #5 clock = ~clock;

   // predictor copy of the ray registers and the running nearest hit
   logic signed [CW-1:0] ray_org [3];
   logic signed [CW-1:0] ray_dir [3];
   logic [rbnp_pkg::DIST_BITS-1:0] near_dist;
   logic [rbnp_pkg::ID_BITS-1:0]   near_id;
   logic                 near_valid;
   pick_type             pending_picks[$];

   int errors = 0;
   int cycles = 0;
   int send_idle = 0;        // percent of cycles the sender holds back
   int recv_idle = 0;        // percent of cycles the receiver holds back
   int hold_off = 0;         // long receiver stall, counted down in cycles

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // exact q16.16 slab parameter, truncated toward zero then saturated
   function automatic logic signed [63:0] slab_param(input logic signed [63:0] num,
                                                     input logic signed [63:0] den);
      logic [63:0] n, d, q, mag;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      if (d == 0) return 0;
      q = n / d;
      if (q >= 64'd32768) mag = SLAB_MAX;
      else mag = (q << rbnp_pkg::FRAC_BITS) + (((n % d) << rbnp_pkg::FRAC_BITS) / d);
      if (mag > SLAB_MAX) mag = SLAB_MAX;
      return ((num < 0) != (den < 0)) ? -$signed(mag) : $signed(mag);
   endfunction

   // slab test of one box; returns hit and the clamped entry distance
   function automatic bit slab_hit(input box_req_type b,
                                   output logic [rbnp_pkg::DIST_BITS-1:0] t_hit);
      logic signed [63:0] t_in, t_out, t1, t2, o, d, lo, hi, s;
      t_in = -(64'sd1 <<< 62);
      t_out = 64'sd1 <<< 62;
      t_hit = '0;
      for (int a = 0; a < 3; a++) begin
         o = ray_org[a];
         d = ray_dir[a];
         lo = (a == 0) ? b.min_x : (a == 1) ? b.min_y : b.min_z;
         hi = (a == 0) ? b.max_x : (a == 1) ? b.max_y : b.max_z;
         if (d == 0) begin
            // parallel axis: origin must sit inside the slab
            if (o < lo || o > hi) return 0;
         end else begin
            t1 = slab_param(lo - o, d);
            t2 = slab_param(hi - o, d);
            if (t1 > t2) begin
               s = t1; t1 = t2; t2 = s;
            end
            if (t1 > t_in) t_in = t1;
            if (t2 < t_out) t_out = t2;
            if (t_in > t_out) return 0;
         end
      end
      // box behind the ray
      if (t_out < 0) return 0;
      t_hit = t_in >= 0 ? t_in[rbnp_pkg::DIST_BITS-1:0] : '0;
      return 1;
   endfunction

   function automatic void clear_pick();
      near_dist = '1;
      near_id = '0;
      near_valid = 1'b0;
   endfunction

   function automatic void predict_box(input box_req_type b);
      logic [rbnp_pkg::DIST_BITS-1:0] t;
      pick_type p;
      // strictly nearer only, so the earlier box keeps a tie
      if (slab_hit(b, t) && (!near_valid || t < near_dist)) begin
         near_dist = t;
         near_id = b.id;
         near_valid = 1'b1;
      end
      if (b.last) begin
         p.found = near_valid;
         p.entity = near_valid ? near_id : '0;
         p.distance = near_valid ? near_dist : '0;
         pending_picks.push_back(p);
         clear_pick();
      end
   endfunction

   // one register write, only while the block is idle
   task automatic write_reg(input logic [rbnp_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [CW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx <= rbnp_pkg::CSR_ORIGIN_Z) ray_org[2'(idx)] = val;
      else ray_dir[2'(idx - rbnp_pkg::CSR_DIR_X)] = val;
   endtask

   task automatic set_ray(input logic [CW-1:0] ox, oy, oz, dx, dy, dz);
      write_reg(rbnp_pkg::CSR_ORIGIN_X, ox);
      write_reg(rbnp_pkg::CSR_ORIGIN_Y, oy);
      write_reg(rbnp_pkg::CSR_ORIGIN_Z, oz);
      write_reg(rbnp_pkg::CSR_DIR_X, dx);
      write_reg(rbnp_pkg::CSR_DIR_Y, dy);
      write_reg(rbnp_pkg::CSR_DIR_Z, dz);
   endtask

   // offer one box; the sender may idle first, then waits for acceptance
   // push stays high after acceptance so back to back boxes need no gap
   task automatic send_box(input box_req_type b);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_box <= b;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_box(b);
      @(negedge clock);
   endtask

   // wait until every pick has come back, then let the block settle
   task automatic drain();
      req_push <= 1'b0;
      while (pending_picks.size() != 0) @(negedge clock);
      repeat (DRAIN_CYC) @(negedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return {1'($urandom_range(1)), ($urandom_range(1) != 0) ? 31'h7fffffff : 31'h0};
         default: return $signed($urandom_range(40 << 16)) - (20 << 16);
      endcase
   endfunction

   function automatic box_req_type rand_box(input bit last);
      box_req_type b;
      logic signed [CW-1:0] p, q;
      p = rand_coord(); q = rand_coord();
      b.min_x = ($urandom_range(9) == 0 || p <= q) ? p : q;
      b.max_x = (b.min_x == p) ? q : p;
      p = rand_coord(); q = rand_coord();
      b.min_y = ($urandom_range(9) == 0 || p <= q) ? p : q;
      b.max_y = (b.min_y == p) ? q : p;
      p = rand_coord(); q = rand_coord();
      b.min_z = ($urandom_range(9) == 0 || p <= q) ? p : q;
      b.max_z = (b.min_z == p) ? q : p;
      b.id = $urandom;
      b.last = last;
      return b;
   endfunction

   function automatic box_req_type mk_box(input int x0, y0, z0, x1, y1, z1,
                                          input logic [31:0] id, input bit last);
      return {x0, y0, z0, x1, y1, z1, id, last};
   endfunction

   // ---------------------------------------------------------------- tests

   // reset ray runs along +z from the origin
   task automatic test_directed();
      // box ahead on z, origin inside x/y
      send_box(mk_box(-65536, -65536, 5 << 16, 65536, 65536, 6 << 16, 32'h11, 1'b0));
      // nearer box, then a tie with it which must lose
      send_box(mk_box(-65536, -65536, 2 << 16, 65536, 65536, 3 << 16, 32'h22, 1'b0));
      send_box(mk_box(-65536, -65536, 2 << 16, 65536, 65536, 9 << 16, 32'h33, 1'b1));
      // box behind the ray
      send_box(mk_box(-65536, -65536, -(6 << 16), 65536, 65536, -(5 << 16), 32'h44, 1'b1));
      // origin inside, entry clamps to zero
      send_box(mk_box(-65536, -65536, -65536, 65536, 65536, 65536, 32'hffffffff, 1'b1));
      // parallel axis with origin outside the slab
      send_box(mk_box(65536, -65536, 65536, 2 << 16, 65536, 2 << 16, 32'h55, 1'b1));
      // inverted box on a parallel axis misses, on the ray axis is swapped
      send_box(mk_box(65536, -65536, 0, -65536, 65536, 65536, 32'h66, 1'b0));
      send_box(mk_box(-65536, -65536, 4 << 16, 65536, 65536, 3 << 16, 32'h77, 1'b1));
      // extreme corners, saturated distances
      send_box(mk_box(32'h80000000, 32'h80000000, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0, 1'b1));
      send_box(mk_box(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'haaaa5555, 1'b1));
      drain();
      // all-parallel ray: hit at zero only when the origin is inside
      set_ray(32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
      send_box(mk_box(0, 0, 0, 2 << 16, 2 << 16, 2 << 16, 32'h88, 1'b0));
      send_box(mk_box(3 << 16, 0, 0, 4 << 16, 2 << 16, 2 << 16, 32'h99, 1'b1));
      drain();
      // extreme ray: tiny negative and positive directions, the most negative direction and far origin
      set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h1, 32'h80000000);
      send_box(mk_box(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h12345678, 1'b1));
      send_box(mk_box(0, 0, 0, 65536, 65536, 65536, 32'h1, 1'b1));
      drain();
   endtask

   // random rays, random short queries
   task automatic test_random(input int n_boxes);
      int sent;
      int qlen;
      sent = 0;
      while (sent < n_boxes) begin
         if ($urandom_range(9) == 0) begin
            drain();
            set_ray(rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(3) == 0 ? 0 : rand_coord(),
                    $urandom_range(3) == 0 ? 0 : rand_coord(),
                    $urandom_range(3) == 0 ? 0 : rand_coord());
         end
         qlen = $urandom_range(1, 6);
         for (int i = 0; i < qlen; i++) send_box(rand_box(i == qlen - 1));
         sent += qlen;
      end
      drain();
   endtask

   // receiver stalls long while the sender keeps pushing, filling the block
   task automatic test_backpressure();
      hold_off = 600;
      for (int i = 0; i < 12; i++) send_box(rand_box(1'b1));
      drain();
   endtask

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_picks.size() == 0) begin
            report_mismatch("unexpected response", rsp_best_entity, 0);
         end else begin
            pick_type want;
            want = pending_picks.pop_front();
            if (rsp_found !== want.found) report_mismatch("found", rsp_found, want.found);
            if (rsp_best_entity !== want.entity)
               report_mismatch("best_entity", rsp_best_entity, want.entity);
            if (rsp_nearest_distance !== want.distance)
               report_mismatch("nearest_distance", rsp_nearest_distance, want.distance);
         end
      end
   end

   // receiver: random pops, or a counted long stall
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycles >= MAX_CYC) begin
         $display("ray_box_nearest_pick regression: fail");
         $finish;
      end
   end

   initial begin
      ray_org = '{default: '0};
      ray_dir = '{0, 0, 32'sh10000};
      clear_pick();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 27; recv_idle = 67;
      test_directed();
      test_backpressure();
      test_random(420);
      send_idle = 67; recv_idle = 27;
      test_random(400);
      send_idle = 0; recv_idle = 0;
      test_random(400);
      if (errors == 0) begin
         $display("ray_box_nearest_pick regression: pass");
      end else begin
         $display("ray_box_nearest_pick regression: fail");
      end
      $finish;
   end

endmodule
